// ----- rtl/core/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, codes and constants shared by the periodic timer table and its RAM.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int MAX_TIMERS_DEF = 8;
	localparam int MAX_RESULTS    = 8;

	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_DISABLED = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_TICK,
		S_RESP
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  timer_handle;
		logic [31:0] delay;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic       fired;
		logic [7:0] fired_handle;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  handle;
		logic [31:0] countdown;
		logic [31:0] reload;
	} entry_t;

	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ----- rtl/core/ptt_ram.sv -----
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [ptt_pkg::addr_bits(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [ptt_pkg::addr_bits(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	import ptt_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/periodic_timer_table.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_table
// Packed table of periodic timers, walked through a RAM one slot per cycle unless a tick holds on a stalled response.
// ----------------------------------------------------------------------------
// Handles, countdowns and reload values live in one RAM with a single read
// and a single write port, and occupied slots are packed from slot 0. One
// command is processed at a time. A set or remove searches the table one slot
// per cycle; a remove that hits shifts the later slots down while it finishes
// the walk. A tick walks all occupied slots and holds its walk while a reported
// firing waits on a stalled response side. Each tick reports at most eight
// fired handles, in slot order, as separate beats; the last beat of every
// command carries last. No clearing pass is needed after reset, since only
// slots below the entry count are ever read.
module periodic_timer_table #(
	parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  ptt_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ptt_pkg::rsp_t rsp
);
	import ptt_pkg::*;

	localparam int AW = addr_bits(MAX_TIMERS);
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam int EW = $bits(entry_t);

	state_t         state_q, state_d;
	logic           enabled_q;
	cmd_t           cmd_q, cmd_d;
	rsp_t           res_q, res_d;
	logic           pend_q, pend_d;
	logic [NW-1:0]  n_q, n_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  rd_idx_q, rd_idx_d;
	logic           vld_s1, vld_d;
	logic [AW-1:0]  idx_s1, idx_d;

	logic           rsp_valid_q;
	rsp_t           rsp_q;
	logic           push;
	rsp_t           push_data;

	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	entry_t         wr_entry, rd_entry;
	logic [EW-1:0]  ram_wdata, ram_rdata;

	logic           cmd_acc;
	logic           can_push;
	logic           walk_done;
	logic           hit;
	logic           tick_fire;
	logic           tick_report;
	logic           walk_hold;

	ptt_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_TIMERS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_wdata = wr_entry;
	assign rd_entry  = entry_t'(ram_rdata);

	assign cfg_ready = 1'b1;
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign can_push  = !rsp_valid_q || !rsp_stall;

	assign walk_done   = !vld_s1 && (rd_idx_q >= count_q);
	assign hit         = vld_s1 && (rd_entry.handle == cmd_q.timer_handle);
	assign tick_fire   = vld_s1 && (rd_entry.countdown == 32'd0);
	assign tick_report = tick_fire && (n_q < NW'(MAX_RESULTS));
	// A new firing pushes out the one held back, which then is known not last.
	assign walk_hold   = (state_q == S_TICK) && tick_report && pend_q && !can_push;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.kind)
						KIND_SET, KIND_REMOVE: begin
							if (!enabled_q || cmd.timer_handle == 8'd0) begin
								state_d = S_RESP;
							end else begin
								state_d = S_SEARCH;
							end
						end
						KIND_TICK: state_d = S_TICK;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_SEARCH: begin
				if (hit) begin
					state_d = (cmd_q.kind == KIND_SET) ? S_RESP : S_SHIFT;
				end else if (walk_done) begin
					state_d = S_RESP;
				end
			end
			S_SHIFT, S_TICK: begin
				if (walk_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (can_push) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath and outputs. Reads always run ahead of writes during a walk,
	// so a slot is never read and written in the same cycle.
	always_comb begin
		cmd_d     = cmd_q;
		res_d     = res_q;
		pend_d    = pend_q;
		n_d       = n_q;
		count_d   = count_q;
		rd_idx_d  = rd_idx_q;
		vld_d     = vld_s1;
		idx_d     = idx_s1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = idx_s1;
		ram_raddr = rd_idx_q[AW-1:0];
		wr_entry  = rd_entry;
		push      = 1'b0;
		push_data = res_q;

		if (state_q == S_SEARCH || state_q == S_SHIFT
				|| (state_q == S_TICK && !walk_hold)) begin
			if (rd_idx_q < count_q) begin
				ram_re   = 1'b1;
				idx_d    = rd_idx_q[AW-1:0];
				rd_idx_d = rd_idx_q + CW'(1);
				vld_d    = 1'b1;
			end else begin
				vld_d = 1'b0;
			end
		end

		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					cmd_d = cmd;
					res_d = '{status: STATUS_OK, fired: 1'b0, fired_handle: 8'd0,
						last: 1'b1};
					if ((cmd.kind == KIND_SET || cmd.kind == KIND_REMOVE) && !enabled_q) begin
						res_d.status = STATUS_DISABLED;
					end
					rd_idx_d = '0;
					vld_d    = 1'b0;
					n_d      = '0;
					pend_d   = 1'b0;
				end
			end
			S_SEARCH: begin
				if (hit) begin
					if (cmd_q.kind == KIND_SET) begin
						ram_we    = 1'b1;
						ram_waddr = idx_s1;
						wr_entry  = '{handle: cmd_q.timer_handle, countdown: cmd_q.delay,
							reload: cmd_q.delay};
					end else begin
						rd_idx_d = CW'(idx_s1) + CW'(1);
						vld_d    = 1'b0;
					end
				end else if (walk_done && cmd_q.kind == KIND_SET) begin
					if (count_q < CW'(MAX_TIMERS)) begin
						ram_we    = 1'b1;
						ram_waddr = count_q[AW-1:0];
						wr_entry  = '{handle: cmd_q.timer_handle, countdown: cmd_q.delay,
							reload: cmd_q.delay};
						count_d   = count_q + CW'(1);
					end else begin
						res_d.status = STATUS_FULL;
					end
				end
			end
			S_SHIFT: begin
				if (vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 - AW'(1);
					wr_entry  = rd_entry;
				end
				if (walk_done) begin
					count_d = count_q - CW'(1);
				end
			end
			S_TICK: begin
				if (vld_s1 && !walk_hold) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1;
					wr_entry  = rd_entry;
					if (tick_fire) begin
						wr_entry.countdown = rd_entry.reload;
					end else begin
						wr_entry.countdown = rd_entry.countdown - 32'd1;
					end
					if (tick_report) begin
						n_d = n_q + NW'(1);
						if (pend_q) begin
							push           = 1'b1;
							push_data      = res_q;
							push_data.last = 1'b0;
						end
						res_d  = '{status: STATUS_OK, fired: 1'b1,
							fired_handle: rd_entry.handle, last: 1'b1};
						pend_d = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (can_push) begin
					push      = 1'b1;
					push_data = res_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enabled_q   <= 1'b0;
			count_q     <= '0;
			vld_s1      <= 1'b0;
			pend_q      <= 1'b0;
			n_q         <= '0;
			rd_idx_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			vld_s1   <= vld_d;
			pend_q   <= pend_d;
			n_q      <= n_d;
			rd_idx_q <= rd_idx_d;
			if (cfg_valid && cfg_ready) begin
				enabled_q <= cfg_data;
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		res_q  <= res_d;
		idx_s1 <= idx_d;
		if (push) begin
			rsp_q <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TIMERS))
		else $error("entry count exceeds table depth");

	a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("table slot read and written in the same cycle");

	a_push_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_push)
		else $error("response beat pushed over an unaccepted beat");

	a_report_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_RESULTS))
		else $error("too many fired handles reported on one tick");

	a_cmd_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> (state_q != S_IDLE))
		else $error("accepted command left the block idle");

endmodule
